// File: hw/rtl/mp2_pkg.sv
// mp2_pkg: constants, types and codes shared by the 2x2 stride-2 max pool.
// No dependencies; used by every module of the block.
package mp2_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_BITS = $clog2(LINE_DEPTH);
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(HEIGHT_LIMIT);
    localparam int WIDTH_REG_BITS = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_HEIGHT = 2'd1;

    localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 11'd2;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd2;

    typedef enum logic {
        OP_STORE,
        OP_EMIT
    } op_kind_t;

    typedef struct packed {
        op_kind_t                       kind;
        logic [SLOT_BITS-1:0]           slot;
        logic signed [SAMPLE_BITS-1:0]  pair;
        logic                           last;
    } op_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  value;
        logic                           done;
    } res_t;

endpackage

// File: hw/rtl/mp2_front.sv
// mp2_front: configuration registers, raster position tracking and pair
// classification into line-store operations. Depends on mp2_pkg.
module mp2_front
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mp2_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [mp2_pkg::CFG_DATA_BITS-1:0]           cfg_data,
    input  logic                                        accept,
    input  logic signed [mp2_pkg::SAMPLE_BITS-1:0]      sample,
    output logic                                        op_push,
    output mp2_pkg::op_t                                op
);

    localparam logic [mp2_pkg::WIDTH_REG_BITS-1:0] W_MIN = 11'd2;
    localparam logic [mp2_pkg::WIDTH_REG_BITS-1:0] W_MAX =
        mp2_pkg::WIDTH_REG_BITS'(mp2_pkg::MAX_WIDTH);
    localparam logic [mp2_pkg::HEIGHT_REG_BITS-1:0] H_MIN = 13'd2;
    localparam logic [mp2_pkg::HEIGHT_REG_BITS-1:0] H_MAX =
        mp2_pkg::HEIGHT_REG_BITS'(mp2_pkg::HEIGHT_LIMIT);

    logic [mp2_pkg::WIDTH_REG_BITS-1:0]     width_reg;
    logic [mp2_pkg::HEIGHT_REG_BITS-1:0]    height_reg;
    logic [mp2_pkg::COL_BITS-1:0]           col_reg, col_next;
    logic [mp2_pkg::ROW_BITS-1:0]           row_reg, row_next;
    logic signed [mp2_pkg::SAMPLE_BITS-1:0] left_reg, left_next;

    logic [mp2_pkg::WIDTH_REG_BITS-1:0]     w, wf, col_inc;
    logic [mp2_pkg::HEIGHT_REG_BITS-1:0]    h, hf, row_inc;
    logic                                   in_pair;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mp2_pkg::WIDTH_RESET;
            height_reg <= mp2_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mp2_pkg::CFG_PLANE_WIDTH:
                    width_reg <= cfg_data[mp2_pkg::WIDTH_REG_BITS-1:0];
                mp2_pkg::CFG_PLANE_HEIGHT:
                    height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < W_MIN)
            w = W_MIN;
        else if (width_reg > W_MAX)
            w = W_MAX;
        else
            w = width_reg;
        if (height_reg < H_MIN)
            h = H_MIN;
        else if (height_reg > H_MAX)
            h = H_MAX;
        else
            h = height_reg;
        wf = {w[mp2_pkg::WIDTH_REG_BITS-1:1], 1'b0};
        hf = {h[mp2_pkg::HEIGHT_REG_BITS-1:1], 1'b0};
        col_inc = {1'b0, col_reg} + 1'b1;
        row_inc = {1'b0, row_reg} + 1'b1;
        in_pair = col_reg[0] && ({1'b0, col_reg} < wf);

        op.kind = row_reg[0] ? mp2_pkg::OP_EMIT : mp2_pkg::OP_STORE;
        op.slot = col_reg[mp2_pkg::COL_BITS-1:1];
        op.pair = (left_reg > sample) ? left_reg : sample;
        op.last = (col_inc == wf) && (row_inc == hf);
        op_push = accept && in_pair && (!row_reg[0] || ({1'b0, row_reg} < hf));

        left_next = left_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            if (!col_reg[0])
                left_next = sample;
            if (col_inc >= w)
            begin
                col_next = '0;
                row_next = (row_inc >= h) ? '0 : row_inc[mp2_pkg::ROW_BITS-1:0];
            end
            else
                col_next = col_inc[mp2_pkg::COL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

endmodule

// File: hw/rtl/mp2_opq.sv
// mp2_opq: short queue of line-store operations between front and back.
// Depends on mp2_pkg.
module mp2_opq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mp2_pkg::op_t    op_in,
    output logic            full,
    input  logic            pop,
    output mp2_pkg::op_t    op_out,
    output logic            empty
);

    mp2_pkg::op_t                       q_reg [mp2_pkg::QUEUE_DEPTH];
    logic [mp2_pkg::QPTR_BITS-1:0]      wr_reg, rd_reg;
    logic [mp2_pkg::QCNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    assign full    = (cnt_reg == mp2_pkg::QCNT_BITS'(mp2_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign op_out  = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_reg] <= op_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/mp2_back.sv
// mp2_back: pair-max line store, vertical compare and result queue.
// Depends on mp2_pkg.
module mp2_back
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    op_empty,
    input  mp2_pkg::op_t                            op,
    output logic                                    op_pop,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [mp2_pkg::SAMPLE_BITS-1:0]  pooled_value,
    output logic                                    plane_done
);

    logic signed [mp2_pkg::SAMPLE_BITS-1:0] line_mem [mp2_pkg::LINE_DEPTH];
    logic signed [mp2_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [mp2_pkg::SAMPLE_BITS-1:0] s2_pair_reg;
    logic                                   s2_last_reg;
    logic                                   s2_valid_reg;

    mp2_pkg::res_t                          rq_reg [mp2_pkg::QUEUE_DEPTH];
    logic [mp2_pkg::QPTR_BITS-1:0]          rwr_reg, rrd_reg;
    logic [mp2_pkg::QCNT_BITS-1:0]          rcnt_reg, rcnt_next;
    logic [mp2_pkg::QCNT_BITS:0]            committed;
    logic                                   room, issue_store, issue_emit, do_pop;
    mp2_pkg::res_t                          res;

    assign committed   = {1'b0, rcnt_reg} + s2_valid_reg;
    assign room        = committed < (mp2_pkg::QCNT_BITS+1)'(mp2_pkg::QUEUE_DEPTH);
    assign issue_store = !op_empty && (op.kind == mp2_pkg::OP_STORE);
    assign issue_emit  = !op_empty && (op.kind == mp2_pkg::OP_EMIT) && room;
    assign op_pop      = issue_store || issue_emit;

    // line store: one write or one registered read per cycle; reads wait for result-queue room
    always_ff @(posedge clk)
    begin
        if (issue_store)
            line_mem[op.slot] <= op.pair;
        if (issue_emit)
        begin
            rd_data_reg <= line_mem[op.slot];
            s2_pair_reg <= op.pair;
            s2_last_reg <= op.last;
        end
    end

    assign res.value = (rd_data_reg > s2_pair_reg) ? rd_data_reg : s2_pair_reg;
    assign res.done  = s2_last_reg;

    assign empty        = (rcnt_reg == '0);
    assign do_pop       = pop && !empty;
    assign pooled_value = rq_reg[rrd_reg].value;
    assign plane_done   = rq_reg[rrd_reg].done;

    always_comb
    begin
        rcnt_next = rcnt_reg;
        if (s2_valid_reg && !do_pop)
            rcnt_next = rcnt_reg + 1'b1;
        else if (do_pop && !s2_valid_reg)
            rcnt_next = rcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            rq_reg[rwr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            rwr_reg      <= '0;
            rrd_reg      <= '0;
            rcnt_reg     <= '0;
        end
        else
        begin
            s2_valid_reg <= issue_emit;
            if (s2_valid_reg)
                rwr_reg <= rwr_reg + 1'b1;
            if (do_pop)
                rrd_reg <= rrd_reg + 1'b1;
            rcnt_reg <= rcnt_next;
        end
    end

endmodule

// File: hw/rtl/max_pool_2x2_stride2.sv
// max_pool_2x2_stride2: top level of the 2x2 stride-2 max pool.
// Depends on mp2_pkg, mp2_front, mp2_opq, mp2_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------
//  input    | push / full            | sample
//  result   | empty / pop            | pooled_value, plane_done
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while full is low. A result reaches the ports once
// the item that completes its window has passed the operation queue, the line
// store's registered read and the result queue; emits wait for result room.
// Reset clears positions and queue counts and sets width and height to 2; line store is not cleared.
// A stalled result side fills the result queue, then the operation queue,
// then raises full; stores drain until a blocked emit reaches the queue head.
module max_pool_2x2_stride2
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    output logic                                        full,
    input  logic signed [mp2_pkg::SAMPLE_BITS-1:0]      sample,
    output logic                                        empty,
    input  logic                                        pop,
    output logic signed [mp2_pkg::SAMPLE_BITS-1:0]      pooled_value,
    output logic                                        plane_done,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mp2_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [mp2_pkg::CFG_DATA_BITS-1:0]           cfg_data
);

    logic           accept;
    logic           op_push, op_pop, op_empty;
    mp2_pkg::op_t   op_in, op_head;

    assign accept = push && !full;

    mp2_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (sample),
        .op_push   (op_push),
        .op        (op_in)
    );

    mp2_opq u_opq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (op_push),
        .op_in  (op_in),
        .full   (full),
        .pop    (op_pop),
        .op_out (op_head),
        .empty  (op_empty)
    );

    mp2_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_empty     (op_empty),
        .op           (op_head),
        .op_pop       (op_pop),
        .empty        (empty),
        .pop          (pop),
        .pooled_value (pooled_value),
        .plane_done   (plane_done)
    );

endmodule

// File: hw/rtl/mp2_checker.sv
// mp2_checker: port-level assertions for max_pool_2x2_stride2, and its bind.
// Depends on mp2_pkg.
module mp2_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    input  logic                                    full,
    input  logic                                    empty,
    input  logic                                    pop,
    input  logic signed [mp2_pkg::SAMPLE_BITS-1:0]  pooled_value,
    input  logic                                    plane_done
);

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not empty in reset");

    a_full_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pooled_value) && $stable(plane_done)))
        else $error("waiting result changed");

    a_empty_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result lost without pop");

endmodule

bind max_pool_2x2_stride2 mp2_checker u_mp2_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .pooled_value (pooled_value),
    .plane_done   (plane_done)
);
